FILE: design/quadratic_root_solver_unit_assert.svh
// Assertion macros for the quadratic root solver unit.
// Both macros expect clk and arst_n to be visible at the place of use.
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QRS_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define QRS_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QRS_CHECK(label, prop, msg)
`define QRS_CHECK_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: design/qrs_pkg.sv
// Package for the quadratic root solver: widths, case codes, context structs
// and the output saturation function. No dependencies.
package qrs_pkg;

	localparam int COEF_FRAC_BITS = 4;
	localparam int IN_W        = 12;
	localparam int CASE_W      = 3;
	localparam int DISC_W      = 25;
	localparam int VAL_W       = 21;
	localparam int PROD_W      = 2 * IN_W;
	localparam int DRAW_W      = PROD_W + 2;
	localparam int MAG_W       = DRAW_W - 1;
	localparam int DSC_W       = DRAW_W + 8;
	localparam int SQ_W        = 21;
	localparam int RAD_W       = 2 * SQ_W;
	localparam int REM_W       = SQ_W + 3;
	localparam int NB_W        = IN_W + 9;
	localparam int NUM_W       = 23;
	localparam int DEN_W       = IN_W + 1;
	localparam int Q_W         = 22;
	localparam int DREM_W      = DEN_W + 1;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 72;

	localparam logic signed [DISC_W-1:0] DISC_MAX = {1'b0, {(DISC_W-1){1'b1}}};
	localparam logic signed [DISC_W-1:0] DISC_MIN = {1'b1, {(DISC_W-1){1'b0}}};
	localparam logic [VAL_W-1:0] VAL_MAX_BITS = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN_BITS = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [Q_W-1:0] Q_LIM_POS = Q_W'((1 << (VAL_W-1)) - 1);
	localparam logic [Q_W-1:0] Q_LIM_NEG = Q_W'(1 << (VAL_W-1));

	typedef enum logic [CASE_W-1:0] {
		RC_LINEAR   = 3'd0,
		RC_TWO_REAL = 3'd1,
		RC_DOUBLE   = 3'd2,
		RC_COMPLEX  = 3'd3,
		RC_DEGEN    = 3'd4
	} root_case_t;

	typedef struct packed {
		root_case_t               rc;
		logic signed [DISC_W-1:0] disc;
	} meta_t;

	typedef struct packed {
		meta_t                   meta;
		logic signed [NB_W-1:0]  nb;   // -256*b
		logic signed [NB_W-1:0]  nc;   // -256*c
		logic signed [DEN_W:0]   den;  // 2a, or b when a is zero
		logic                    dpos;
		logic                    dneg;
	} sq_ctx_t;

	typedef struct packed {
		meta_t            meta;
		logic             neg1;
		logic             neg2;
		logic [DEN_W-1:0] dmag;
	} div_ctx_t;

	// apply sign to an unsigned quotient and clamp to the value range
	function automatic logic [VAL_W-1:0] sat_val(input logic [Q_W-1:0] q, input logic neg);
		logic [Q_W-1:0]   lim;
		logic [VAL_W-1:0] r;
		lim = neg ? Q_LIM_NEG : Q_LIM_POS;
		r = q[VAL_W-1:0];
		if (q > lim) begin
			r = neg ? VAL_MIN_BITS : VAL_MAX_BITS;
		end else if (neg) begin
			r = ~r + 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: design/quadratic_root_solver_unit.sv
// Quadratic root solver: products, discriminant, 21-stage square root, two 22-stage dividers.
// One beat per cycle sustained while the output skid register is not full,
// as the square root and restoring divider pipelines resolve one bit per stage.
// A two-entry output register/skid lets the pipe run while a result waits.
// arst_n clears all valid bits; payload registers are not reset.
// Depends on qrs_pkg and quadratic_root_solver_unit_assert.svh.
`include "quadratic_root_solver_unit_assert.svh"
module quadratic_root_solver_unit import qrs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // coef_a, coef_b, coef_c, zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // discriminant, first_value, second_value, pad
	output logic [CASE_W-1:0]      m_tuser    // root_case
);

	localparam int FB2  = 2 * COEF_FRAC_BITS;
	localparam int UP   = (FB2 <= 8) ? (8 - FB2) : 0;
	localparam int DN   = (FB2 > 8) ? (FB2 - 8) : 0;
	localparam int HALF = (1 << DN) >> 1;

	logic en;

	// ---------------- stage 1: input register
	logic                    v_s1;
	logic signed [IN_W-1:0]  a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= signed'(s_tdata[IN_W-1:0]);
			b_s1 <= signed'(s_tdata[2*IN_W-1:IN_W]);
			c_s1 <= signed'(s_tdata[3*IN_W-1:2*IN_W]);
		end
	end

	// ---------------- stage 2: products
	logic                     v_s2;
	logic signed [PROD_W-1:0] bb_s2, ac_s2;
	logic signed [IN_W-1:0]   a_s2, b_s2, c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s2 <= b_s1 * b_s1;
			ac_s2 <= a_s1 * c_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			c_s2  <= c_s1;
		end
	end

	// ---------------- stage 3: discriminant, case, root setup
	logic signed [DRAW_W-1:0] draw;
	logic [MAG_W-1:0]         mag;
	logic [DRAW_W-1:0]        mr;
	logic signed [DSC_W-1:0]  dsh;
	logic signed [DISC_W-1:0] disc_sat;
	logic                     az, bz;
	sq_ctx_t                  ctx3;

	always_comb begin
		draw = DRAW_W'(bb_s2) - (DRAW_W'(ac_s2) <<< 2);
		mag  = draw[DRAW_W-1] ? MAG_W'(-draw) : MAG_W'(draw);
		mr   = (DRAW_W'(mag) + DRAW_W'(HALF)) >> DN;
		if (DN == 0) dsh = DSC_W'(draw) <<< UP;
		else dsh = draw[DRAW_W-1] ? -DSC_W'(mr) : DSC_W'(mr);
		if (dsh > DSC_W'(DISC_MAX)) disc_sat = DISC_MAX;
		else if (dsh < DSC_W'(DISC_MIN)) disc_sat = DISC_MIN;
		else disc_sat = dsh[DISC_W-1:0];

		az = (a_s2 == '0);
		bz = (b_s2 == '0);
		if (az) ctx3.meta.rc = bz ? RC_DEGEN : RC_LINEAR;
		else if (draw > 0) ctx3.meta.rc = RC_TWO_REAL;
		else if (draw == 0) ctx3.meta.rc = RC_DOUBLE;
		else ctx3.meta.rc = RC_COMPLEX;
		ctx3.meta.disc = az ? '0 : disc_sat;
		ctx3.nb   = -(NB_W'(b_s2) <<< 8);
		ctx3.nc   = -(NB_W'(c_s2) <<< 8);
		ctx3.den  = az ? (DEN_W+1)'(b_s2) : ((DEN_W+1)'(a_s2) <<< 1);
		ctx3.dpos = (draw > 0);
		ctx3.dneg = draw[DRAW_W-1];
	end

	// ---------------- square root: one result bit per stage
	logic                sq_v    [0:SQ_W];
	sq_ctx_t             sq_ctx  [0:SQ_W];
	logic [RAD_W-1:0]    sq_rad  [0:SQ_W];
	logic [SQ_W-1:0]     sq_root [0:SQ_W];
	logic [REM_W-1:0]    sq_rem  [0:SQ_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v[0] <= 1'b0;
		else if (en) sq_v[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_ctx[0]  <= ctx3;
			sq_rad[0]  <= RAD_W'({mag, 16'b0});
			sq_root[0] <= '0;
			sq_rem[0]  <= '0;
		end
	end

	for (genvar j = 1; j <= SQ_W; j++) begin : g_sqrt
		logic [REM_W-1:0] rem_n, trial;
		logic             ge;
		always_comb begin
			rem_n = {sq_rem[j-1][REM_W-3:0], sq_rad[j-1][RAD_W-1 -: 2]};
			trial = REM_W'({sq_root[j-1], 2'b01});
			ge    = (rem_n >= trial);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[j] <= 1'b0;
			else if (en) sq_v[j] <= sq_v[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_ctx[j]  <= sq_ctx[j-1];
				sq_rad[j]  <= sq_rad[j-1] << 2;
				sq_root[j] <= {sq_root[j-1][SQ_W-2:0], ge};
				sq_rem[j]  <= ge ? (rem_n - trial) : rem_n;
			end
		end
	end

	// ---------------- numerator forming
	sq_ctx_t                 sc;
	logic signed [NUM_W-1:0] nb_x, s_x, n1, n2;
	logic [NUM_W-1:0]        m1, m2;
	logic [DEN_W-1:0]        dmag;
	div_ctx_t                dctx;
	logic [Q_W-1:0]          u1_0, u2_0;

	always_comb begin
		sc   = sq_ctx[SQ_W];
		nb_x = NUM_W'(sc.nb);
		s_x  = signed'(NUM_W'(sq_root[SQ_W]));
		if (sc.meta.rc == RC_LINEAR) n1 = NUM_W'(sc.nc);
		else n1 = sc.dpos ? (nb_x - s_x) : nb_x;
		n2   = sc.dneg ? s_x : (nb_x + s_x);
		m1   = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
		m2   = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
		dmag = sc.den[DEN_W] ? DEN_W'(-sc.den) : DEN_W'(sc.den);
		u1_0 = Q_W'(m1) + Q_W'(dmag >> 1);
		u2_0 = Q_W'(m2) + Q_W'(dmag >> 1);
		dctx.meta = sc.meta;
		dctx.neg1 = n1[NUM_W-1] ^ sc.den[DEN_W];
		dctx.neg2 = n2[NUM_W-1] ^ sc.den[DEN_W];
		dctx.dmag = dmag;
	end

	// ---------------- dividers: one quotient bit per stage, both roots side by side
	logic              d_v   [0:Q_W];
	div_ctx_t          d_ctx [0:Q_W];
	logic [Q_W-1:0]    d_u1  [0:Q_W];
	logic [Q_W-1:0]    d_u2  [0:Q_W];
	logic [DREM_W-1:0] d_r1  [0:Q_W];
	logic [DREM_W-1:0] d_r2  [0:Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d_v[0] <= 1'b0;
		else if (en) d_v[0] <= sq_v[SQ_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_ctx[0] <= dctx;
			d_u1[0]  <= u1_0;
			d_u2[0]  <= u2_0;
			d_r1[0]  <= '0;
			d_r2[0]  <= '0;
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_div
		logic [DREM_W-1:0] rn1, rn2, dd;
		logic              ge1, ge2;
		always_comb begin
			dd  = DREM_W'(d_ctx[k-1].dmag);
			rn1 = {d_r1[k-1][DREM_W-2:0], d_u1[k-1][Q_W-1]};
			rn2 = {d_r2[k-1][DREM_W-2:0], d_u2[k-1][Q_W-1]};
			ge1 = (rn1 >= dd);
			ge2 = (rn2 >= dd);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d_v[k] <= 1'b0;
			else if (en) d_v[k] <= d_v[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_ctx[k] <= d_ctx[k-1];
				d_u1[k]  <= {d_u1[k-1][Q_W-2:0], ge1};
				d_u2[k]  <= {d_u2[k-1][Q_W-2:0], ge2};
				d_r1[k]  <= ge1 ? (rn1 - dd) : rn1;
				d_r2[k]  <= ge2 ? (rn2 - dd) : rn2;
			end
		end
	end

	// ---------------- result and output register with skid
	div_ctx_t               fc;
	logic [VAL_W-1:0]       v1, v2;
	logic [OUT_TDATA_W-1:0] res_data;
	logic [CASE_W-1:0]      res_user;

	always_comb begin
		fc = d_ctx[Q_W];
		v1 = (fc.meta.rc == RC_DEGEN) ? '0 : sat_val(d_u1[Q_W], fc.neg1);
		v2 = (fc.meta.rc == RC_DEGEN || fc.meta.rc == RC_LINEAR) ? '0
			: sat_val(d_u2[Q_W], fc.neg2);
		res_data = OUT_TDATA_W'({v2, v1, fc.meta.disc});
		res_user = fc.meta.rc;
	end

	logic                   out_v_q, skid_v_q;
	logic [OUT_TDATA_W-1:0] out_data_q, skid_data_q;
	logic [CASE_W-1:0]      out_user_q, skid_user_q;
	logic                   out_free;

	assign en       = !skid_v_q;
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || (en && d_v[Q_W]);
			skid_v_q <= 1'b0;
		end else if (en && d_v[Q_W]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end else begin
				out_data_q <= res_data;
				out_user_q <= res_user;
			end
		end else if (en && d_v[Q_W]) begin
			skid_data_q <= res_data;
			skid_user_q <= res_user;
		end
	end

	assign s_tready = en;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	`QRS_CHECK(a_skid_needs_out, skid_v_q |-> out_v_q, "skid beat held with empty output")
	`QRS_CHECK_NEXT(a_skid_hold, skid_v_q && !m_tready, skid_v_q, "skid beat dropped on stall")
	`QRS_CHECK_NEXT(a_in_to_s1, s_tvalid && s_tready, v_s1, "accepted beat missing in stage 1")
	`QRS_CHECK(a_degen_zero, (m_tvalid && m_tuser == RC_DEGEN) |-> (m_tdata[DISC_W+2*VAL_W-1:0] == '0), "degenerate result not zero")

endmodule
